// ===== hw/rtl/sensor_decimating_averager_with_tare_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sensor averager
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_DECIMATING_AVERAGER_WITH_TARE_DEFINES_SVH
`define SENSOR_DECIMATING_AVERAGER_WITH_TARE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clock, off during reset
`define SDAT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sdat: same-cycle check failed");
// next-cycle implication, sampled on clock, off during reset
`define SDAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sdat: next-cycle check failed");
`else
`define SDAT_ASSERT_SAME(label, ante, cons)
`define SDAT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/sdat_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor averager package
// Field widths, reset values, pressure scaling constants and shared types.
// ----------------------------------------------------------------------------
package sdat_pkg;

   localparam int CODE_W     = 12;
   localparam int MBAR_W     = 17;
   localparam int PRESS_W    = 18;
   localparam int TEMP_W     = 16;
   localparam int PSUM_W     = 24;
   localparam int TSUM_W     = 21;
   localparam int CALIB_W    = 32;
   localparam int BASE_W     = 16;
   localparam int PROG_W     = 4;
   localparam int TIDX_W     = 10;
   localparam int CMIN_W     = 12;
   localparam int CMAX_W     = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [BASE_W-1:0] BASE_RESET  = 16'd1000;
   localparam logic [BASE_W-1:0] BASE_OFFSET = 16'd1000;
   localparam logic [CMAX_W-1:0] CMAX_RESET  = 13'd1024;
   localparam logic [CMIN_W-1:0] CMIN_RESET  = 12'd0;

   // calibration: eight averages summed, base taken at the ninth
   localparam logic [PROG_W-1:0] CALIB_WINDOWS = 4'd8;
   localparam logic [PROG_W-1:0] CALIB_DONE    = 4'd9;
   localparam int                CALIB_SHIFT   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_CODE_MIN = 1'b0,
      CSR_TEMP_CODE_MAX = 1'b1
   } csr_index_type;

   // mbar = floor(code * num * 3300e6 / (den * 4096 * 4700))
   // 3300e6 / (4096 * 4700) reduces to 515625 / 3008
   localparam logic [63:0] SCALE_NUM = 64'd515625;
   localparam logic [63:0] SCALE_DEN = 64'd3008;

   // ceil(2^40 * K / D) built in three steps to stay inside 64 bits;
   // 2^40 exceeds 4095 * D, so code * RECIP >> 40 is the exact floor
   localparam int RECIP_SHIFT = 40;
   localparam int RECIP_STEP  = 20;
   localparam int RECIP_W     = 45;

   localparam logic [63:0] PA_K  = 64'd6499 * SCALE_NUM;
   localparam logic [63:0] PA_D  = 64'd64271 * SCALE_DEN;
   localparam logic [63:0] PA_Q0 = PA_K / PA_D;
   localparam logic [63:0] PA_R0 = PA_K % PA_D;
   localparam logic [63:0] PA_Q1 = (PA_R0 << RECIP_STEP) / PA_D;
   localparam logic [63:0] PA_R1 = (PA_R0 << RECIP_STEP) % PA_D;
   localparam logic [63:0] PA_Q2 = ((PA_R1 << RECIP_STEP) + PA_D - 64'd1) / PA_D;
   localparam logic [63:0] PA_RECIP = (PA_Q0 << RECIP_SHIFT) + (PA_Q1 << RECIP_STEP) + PA_Q2;

   localparam logic [63:0] PB_K  = 64'd6498 * SCALE_NUM;
   localparam logic [63:0] PB_D  = 64'd64341 * SCALE_DEN;
   localparam logic [63:0] PB_Q0 = PB_K / PB_D;
   localparam logic [63:0] PB_R0 = PB_K % PB_D;
   localparam logic [63:0] PB_Q1 = (PB_R0 << RECIP_STEP) / PB_D;
   localparam logic [63:0] PB_R1 = (PB_R0 << RECIP_STEP) % PB_D;
   localparam logic [63:0] PB_Q2 = ((PB_R1 << RECIP_STEP) + PB_D - 64'd1) / PB_D;
   localparam logic [63:0] PB_RECIP = (PB_Q0 << RECIP_SHIFT) + (PB_Q1 << RECIP_STEP) + PB_Q2;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } lut_ctl_type;

endpackage

// ===== hw/rtl/sdat_mbar.sv =====
// ----------------------------------------------------------------------------
// Pressure code to millibar
// Reciprocal multiply of both pressure codes, result registered.
// ----------------------------------------------------------------------------
module sdat_mbar import sdat_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  logic [CODE_W-1:0] code_a,
   input  logic [CODE_W-1:0] code_b,
   output logic [MBAR_W-1:0] mbar_a,
   output logic [MBAR_W-1:0] mbar_b
);

   localparam int PROD_W = CODE_W + RECIP_W;

   logic [PROD_W-1:0] prod_a;
   logic [PROD_W-1:0] prod_b;
   logic [MBAR_W-1:0] mbar_a_in;
   logic [MBAR_W-1:0] mbar_b_in;
   logic [MBAR_W-1:0] mbar_a_ff;
   logic [MBAR_W-1:0] mbar_b_ff;

   assign prod_a    = PROD_W'(code_a) * PROD_W'(PA_RECIP[RECIP_W-1:0]);
   assign prod_b    = PROD_W'(code_b) * PROD_W'(PB_RECIP[RECIP_W-1:0]);
   assign mbar_a_in = prod_a[RECIP_SHIFT +: MBAR_W];
   assign mbar_b_in = prod_b[RECIP_SHIFT +: MBAR_W];

   always_ff @(posedge clock) begin
      if (load) begin
         mbar_a_ff <= mbar_a_in;
         mbar_b_ff <= mbar_b_in;
      end
   end

   assign mbar_a = mbar_a_ff;
   assign mbar_b = mbar_b_ff;

endmodule

// ===== hw/rtl/sdat_temp_lut.sv =====
// ----------------------------------------------------------------------------
// Temperature lookup bank
// One copy of the temperature table: window check, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module sdat_temp_lut import sdat_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                     clock,
   input  lut_ctl_type              ctl,
   input  logic [CODE_W-1:0]        code,
   input  logic [CMIN_W-1:0]        code_min,
   input  logic [CMAX_W-1:0]        code_max,
   input  logic [TIDX_W-1:0]        wr_index,
   input  logic signed [TEMP_W-1:0] wr_word,
   output logic signed [TEMP_W-1:0] value
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [TEMP_W-1:0] temp_table_ff [TABLE_DEPTH];
   logic [TEMP_W-1:0] rd_data_ff;
   logic              rd_hit_ff;
   logic              rd_hit_in;
   logic [CMAX_W-1:0] rd_off;
   logic [CMAX_W-1:0] wr_ext;
   logic              wr_ok;

   assign rd_off    = {1'b0, code} - {1'b0, code_min};
   assign rd_hit_in = (code >= code_min) && ({1'b0, code} < code_max)
                      && (rd_off < CMAX_W'(TABLE_DEPTH));
   assign wr_ext    = CMAX_W'(wr_index);
   assign wr_ok     = wr_ext < CMAX_W'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (ctl.wr_en && wr_ok) begin
         temp_table_ff[wr_ext[IDX_W-1:0]] <= wr_word;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= temp_table_ff[rd_off[IDX_W-1:0]];
         rd_hit_ff  <= rd_hit_in;
      end
   end

   // out of window reads add nothing
   assign value = rd_hit_ff ? signed'(rd_data_ff) : '0;

endmodule

// ===== hw/rtl/sdat_accum.sv =====
// ----------------------------------------------------------------------------
// Accumulate, decimate and tare
// Running sums, window counter, calibration of the pressure bases and
// the result register.
// ----------------------------------------------------------------------------
module sdat_accum import sdat_pkg::*; #(
   parameter int AVG_SHIFT = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      b_frame,
   input  logic [MBAR_W-1:0]         mbar_a,
   input  logic [MBAR_W-1:0]         mbar_b,
   input  logic signed [TEMP_W-1:0]  temp_a,
   input  logic signed [TEMP_W-1:0]  temp_b,
   input  logic signed [TEMP_W-1:0]  temp_c,
   input  logic                      rsp_stall,
   output logic                      hold,
   output logic                      rsp_valid,
   output logic signed [PRESS_W-1:0] press_a_avg,
   output logic signed [PRESS_W-1:0] press_b_avg,
   output logic signed [TEMP_W-1:0]  temp_a_avg,
   output logic signed [TEMP_W-1:0]  temp_b_avg,
   output logic signed [TEMP_W-1:0]  temp_c_avg,
   output logic                      tare_done
);

   logic [AVG_SHIFT-1:0]      frame_count_ff;
   logic signed [PSUM_W-1:0]  psum_a_ff;
   logic signed [PSUM_W-1:0]  psum_b_ff;
   logic signed [TSUM_W-1:0]  tsum_ff [3];
   logic signed [TEMP_W-1:0]  temp_val [3];
   logic signed [PSUM_W-1:0]  psum_a_in;
   logic signed [PSUM_W-1:0]  psum_b_in;
   logic signed [TSUM_W-1:0]  tsum_in [3];
   logic signed [PSUM_W-1:0]  avg_a_full;
   logic signed [PSUM_W-1:0]  avg_b_full;
   logic signed [TSUM_W-1:0]  tavg [3];
   logic [CALIB_W-1:0]        calib_a_ff;
   logic [CALIB_W-1:0]        calib_b_ff;
   logic [BASE_W-1:0]         base_a_ff;
   logic [BASE_W-1:0]         base_b_ff;
   logic [PROG_W-1:0]         progress_ff;
   logic                      pend_ff;
   logic signed [PSUM_W-1:0]  pend_a_ff;
   logic signed [PSUM_W-1:0]  pend_b_ff;
   logic                      rsp_valid_ff;
   logic signed [PRESS_W-1:0] press_a_ff;
   logic signed [PRESS_W-1:0] press_b_ff;
   logic signed [TEMP_W-1:0]  temp_avg_ff [3];
   logic                      tare_done_ff;
   logic                      window_end;
   logic                      step;
   logic                      close;

   assign temp_val[0] = temp_a;
   assign temp_val[1] = temp_b;
   assign temp_val[2] = temp_c;

   assign window_end = &frame_count_ff;
   assign hold       = b_frame && window_end && rsp_valid_ff && rsp_stall;
   assign step       = b_frame && !hold;
   assign close      = step && window_end;

   // tared value: mbar - (base - 1000), wrapping at the sum width
   assign psum_a_in = psum_a_ff + PSUM_W'(mbar_a) + PSUM_W'(BASE_OFFSET) - PSUM_W'(base_a_ff);
   assign psum_b_in = psum_b_ff + PSUM_W'(mbar_b) + PSUM_W'(BASE_OFFSET) - PSUM_W'(base_b_ff);
   assign avg_a_full = psum_a_in >>> AVG_SHIFT;
   assign avg_b_full = psum_b_in >>> AVG_SHIFT;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tsum_in[i] = tsum_ff[i] + TSUM_W'(temp_val[i]);
         tavg[i]    = tsum_in[i] >>> AVG_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         psum_a_ff      <= '0;
         psum_b_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            tsum_ff[i] <= '0;
         end
         calib_a_ff     <= '0;
         calib_b_ff     <= '0;
         base_a_ff      <= BASE_RESET;
         base_b_ff      <= BASE_RESET;
         progress_ff    <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (step) begin
            frame_count_ff <= frame_count_ff + AVG_SHIFT'(1);
            psum_a_ff      <= close ? '0 : psum_a_in;
            psum_b_ff      <= close ? '0 : psum_b_in;
            for (int i = 0; i < 3; i++) begin
               tsum_ff[i] <= close ? '0 : tsum_in[i];
            end
         end

         if (close) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // fold the window average into calibration in the cycle after the window closes
         pend_ff <= close && (progress_ff < CALIB_WINDOWS);
         if (pend_ff) begin
            calib_a_ff <= calib_a_ff + CALIB_W'(pend_a_ff);
            calib_b_ff <= calib_b_ff + CALIB_W'(pend_b_ff);
         end

         if (close) begin
            if (progress_ff < CALIB_WINDOWS) begin
               progress_ff <= progress_ff + PROG_W'(1);
            end else if (progress_ff == CALIB_WINDOWS) begin
               base_a_ff   <= calib_a_ff[CALIB_SHIFT +: BASE_W];
               base_b_ff   <= calib_b_ff[CALIB_SHIFT +: BASE_W];
               progress_ff <= CALIB_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (close) begin
         pend_a_ff    <= avg_a_full;
         pend_b_ff    <= avg_b_full;
         press_a_ff   <= avg_a_full[PRESS_W-1:0];
         press_b_ff   <= avg_b_full[PRESS_W-1:0];
         for (int i = 0; i < 3; i++) begin
            temp_avg_ff[i] <= tavg[i][TEMP_W-1:0];
         end
         tare_done_ff <= (progress_ff == CALIB_WINDOWS) || (progress_ff == CALIB_DONE);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign press_a_avg = press_a_ff;
   assign press_b_avg = press_b_ff;
   assign temp_a_avg  = temp_avg_ff[0];
   assign temp_b_avg  = temp_avg_ff[1];
   assign temp_c_avg  = temp_avg_ff[2];
   assign tare_done   = tare_done_ff;

endmodule

// ===== hw/rtl/sensor_decimating_averager_with_tare.sv =====
// ----------------------------------------------------------------------------
// Sensor decimating averager with tare
// Two pressure and three temperature channels, boxcar averaged over
// 2^AVG_SHIFT frames, with automatic pressure tare and a loadable
// temperature table.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  action, codes, table entry
//  rsp_     out        rsp_valid/rsp_stall  five averages, tare_done
//  csr_     in         csr_valid/csr_ready  index, data (always ready)
//
//  One item is taken every clock unless a held result stalls the input. A
//  frame is registered in stage A when accepted, converted and looked up
//  into stage B, and a closing frame then loads the result register.
//  The rate is set by the single read port of each temperature table
//  copy: three identical copies serve the three channels at once.
//  Reset clears control, sums, counters and sets both bases to 1000; the
//  table contents are left as they are and are not cleared by reset.
//  rsp_stall backs up into req_stall only when a window-closing frame
//  meets a result that has not been transferred yet.
//
`include "sensor_decimating_averager_with_tare_defines.svh"

module sensor_decimating_averager_with_tare import sdat_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int AVG_SHIFT   = 5
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [CODE_W-1:0]         req_raw_press_a,
   input  logic [CODE_W-1:0]         req_raw_press_b,
   input  logic [CODE_W-1:0]         req_raw_temp_a,
   input  logic [CODE_W-1:0]         req_raw_temp_b,
   input  logic [CODE_W-1:0]         req_raw_temp_c,
   input  logic [TIDX_W-1:0]         req_table_index,
   input  logic signed [TEMP_W-1:0]  req_table_word,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [PRESS_W-1:0] rsp_press_a_avg,
   output logic signed [PRESS_W-1:0] rsp_press_b_avg,
   output logic signed [TEMP_W-1:0]  rsp_temp_a_avg,
   output logic signed [TEMP_W-1:0]  rsp_temp_b_avg,
   output logic signed [TEMP_W-1:0]  rsp_temp_c_avg,
   output logic                      rsp_tare_done,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   // configuration registers
   logic [CMIN_W-1:0] code_min_ff;
   logic [CMAX_W-1:0] code_max_ff;

   // input register (stage A)
   logic                     a_valid_ff;
   logic                     a_action_ff;
   logic [CODE_W-1:0]        a_press_a_ff;
   logic [CODE_W-1:0]        a_press_b_ff;
   logic [CODE_W-1:0]        a_temp_a_ff;
   logic [CODE_W-1:0]        a_temp_b_ff;
   logic [CODE_W-1:0]        a_temp_c_ff;
   logic [TIDX_W-1:0]        a_tidx_ff;
   logic signed [TEMP_W-1:0] a_tword_ff;

   // converted stage (stage B) control; its data lives in the units
   logic b_valid_ff;
   logic b_action_ff;
   logic b_frame;

   logic a_free;
   logic b_free;
   logic adv_a;
   logic hold;

   lut_ctl_type              lut_ctl;
   logic [MBAR_W-1:0]        mbar_a;
   logic [MBAR_W-1:0]        mbar_b;
   logic signed [TEMP_W-1:0] temp_a;
   logic signed [TEMP_W-1:0] temp_b;
   logic signed [TEMP_W-1:0] temp_c;

   // ---- configuration port: always ready; the user writes it only while idle, the block does not enforce it ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_min_ff <= CMIN_RESET;
         code_max_ff <= CMAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP_CODE_MIN: code_min_ff <= csr_data[CMIN_W-1:0];
            CSR_TEMP_CODE_MAX: code_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---- pipeline flow ----
   // Stage B drains unless a closing frame is blocked by a held result;
   // stage A advances whenever B is free, so the input takes a transfer
   // every clock in the common case.
   assign b_free    = !hold;
   assign adv_a     = a_valid_ff && b_free;
   assign a_free    = !a_valid_ff || b_free;
   assign req_stall = !a_free;
   assign b_frame   = b_valid_ff && !b_action_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         a_action_ff <= 1'b0;
         b_valid_ff  <= 1'b0;
         b_action_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff  <= req_valid;
            a_action_ff <= req_action;
         end
         if (b_free) begin
            b_valid_ff  <= a_valid_ff;
            b_action_ff <= a_action_ff;
         end
      end
   end

   // capture the payload on every input transfer
   always_ff @(posedge clock) begin
      if (a_free && req_valid) begin
         a_press_a_ff <= req_raw_press_a;
         a_press_b_ff <= req_raw_press_b;
         a_temp_a_ff  <= req_raw_temp_a;
         a_temp_b_ff  <= req_raw_temp_b;
         a_temp_c_ff  <= req_raw_temp_c;
         a_tidx_ff    <= req_table_index;
         a_tword_ff   <= req_table_word;
      end
   end

   // frames read the table, table writes update all three copies
   assign lut_ctl.rd_en = adv_a && !a_action_ff;
   assign lut_ctl.wr_en = adv_a && a_action_ff;

   // ---- stage A to B: pressure scaling and table lookups ----
   sdat_mbar u_mbar (
      .clock  (clock),
      .load   (lut_ctl.rd_en),
      .code_a (a_press_a_ff),
      .code_b (a_press_b_ff),
      .mbar_a (mbar_a),
      .mbar_b (mbar_b)
   );

   sdat_temp_lut #(.TABLE_DEPTH(TABLE_DEPTH)) u_lut_a (
      .clock    (clock),
      .ctl      (lut_ctl),
      .code     (a_temp_a_ff),
      .code_min (code_min_ff),
      .code_max (code_max_ff),
      .wr_index (a_tidx_ff),
      .wr_word  (a_tword_ff),
      .value    (temp_a)
   );

   sdat_temp_lut #(.TABLE_DEPTH(TABLE_DEPTH)) u_lut_b (
      .clock    (clock),
      .ctl      (lut_ctl),
      .code     (a_temp_b_ff),
      .code_min (code_min_ff),
      .code_max (code_max_ff),
      .wr_index (a_tidx_ff),
      .wr_word  (a_tword_ff),
      .value    (temp_b)
   );

   sdat_temp_lut #(.TABLE_DEPTH(TABLE_DEPTH)) u_lut_c (
      .clock    (clock),
      .ctl      (lut_ctl),
      .code     (a_temp_c_ff),
      .code_min (code_min_ff),
      .code_max (code_max_ff),
      .wr_index (a_tidx_ff),
      .wr_word  (a_tword_ff),
      .value    (temp_c)
   );

   // ---- stage B to result: accumulate, decimate, tare ----
   sdat_accum #(.AVG_SHIFT(AVG_SHIFT)) u_accum (
      .clock       (clock),
      .reset       (reset),
      .b_frame     (b_frame),
      .mbar_a      (mbar_a),
      .mbar_b      (mbar_b),
      .temp_a      (temp_a),
      .temp_b      (temp_b),
      .temp_c      (temp_c),
      .rsp_stall   (rsp_stall),
      .hold        (hold),
      .rsp_valid   (rsp_valid),
      .press_a_avg (rsp_press_a_avg),
      .press_b_avg (rsp_press_b_avg),
      .temp_a_avg  (rsp_temp_a_avg),
      .temp_b_avg  (rsp_temp_b_avg),
      .temp_c_avg  (rsp_temp_c_avg),
      .tare_done   (rsp_tare_done)
   );

   // ---- checks ----
   // a new result only follows a sample frame leaving stage B
   `SDAT_ASSERT_SAME(a_rsp_from_frame, $rose(rsp_valid), $past(b_frame))
   // input backs up only behind a result waiting on the output
   `SDAT_ASSERT_SAME(a_stall_needs_held_rsp, req_stall, rsp_valid && rsp_stall)
   // a blocked closing frame stays in stage B
   `SDAT_ASSERT_NEXT(a_blocked_frame_stays, hold, b_frame)

endmodule

// ===== tb/tb_sensor_decimating_averager_with_tare.sv =====
// ----------------------------------------------------------------------------
// Testbench for the sensor decimating averager with tare
// Drives ADC frames and temperature table writes through the request
// channel and predicts every window average, including the automatic tare
// after calibration. Each result transfer is compared field by field with
// the prediction while the sender idles and the receiver stalls at random and the temperature
// window registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_sensor_decimating_averager_with_tare import sdat_pkg::*; ();

   // averaging and table geometry of the instance under test
   localparam int LUT_DEPTH = 1024;
   localparam int AVG_SH    = 5;
   localparam int WINDOW    = 1 << AVG_SH;

   // pressure scaling: mbar = code * gain * vref * 1e6 / (div * 4096 * r_low)
   localparam longint PA_GAIN   = 6499;
   localparam longint PA_DIV    = 64271;
   localparam longint PB_GAIN   = 6498;
   localparam longint PB_DIV    = 64341;
   localparam longint VREF_MV   = 3300;
   localparam longint MICRO     = 1000000;
   localparam longint ADC_SPAN  = 4096;
   localparam longint R_LOW     = 4700;
   localparam longint TARE_ZERO = 1000;

   // stimulus shaping
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_ITEMS    = 287;
   localparam int TABLE_PCT      = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum bit {
      ACT_FRAME = 1'b0,
      ACT_TABLE = 1'b1
   } adc_action_type;

   typedef struct {
      adc_action_type    action;
      logic [CODE_W-1:0] press_a;
      logic [CODE_W-1:0] press_b;
      logic [CODE_W-1:0] temp_a;
      logic [CODE_W-1:0] temp_b;
      logic [CODE_W-1:0] temp_c;
      logic [TIDX_W-1:0] index;
      logic [TEMP_W-1:0] word;
   } adc_item_type;

   typedef struct {
      logic [PRESS_W-1:0] press_a;
      logic [PRESS_W-1:0] press_b;
      logic [TEMP_W-1:0]  temp_a;
      logic [TEMP_W-1:0]  temp_b;
      logic [TEMP_W-1:0]  temp_c;
      logic               tare_done;
   } window_avg_type;

   // ------------------------------------------------------------------
   // DUT signals, all at known values from time zero
   // ------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_action = 1'b0;
   logic [CODE_W-1:0]         req_raw_press_a = '0;
   logic [CODE_W-1:0]         req_raw_press_b = '0;
   logic [CODE_W-1:0]         req_raw_temp_a = '0;
   logic [CODE_W-1:0]         req_raw_temp_b = '0;
   logic [CODE_W-1:0]         req_raw_temp_c = '0;
   logic [TIDX_W-1:0]         req_table_index = '0;
   logic signed [TEMP_W-1:0]  req_table_word = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [PRESS_W-1:0] rsp_press_a_avg;
   logic signed [PRESS_W-1:0] rsp_press_b_avg;
   logic signed [TEMP_W-1:0]  rsp_temp_a_avg;
   logic signed [TEMP_W-1:0]  rsp_temp_b_avg;
   logic signed [TEMP_W-1:0]  rsp_temp_c_avg;
   logic                      rsp_tare_done;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   sensor_decimating_averager_with_tare i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_raw_press_a (req_raw_press_a),
      .req_raw_press_b (req_raw_press_b),
      .req_raw_temp_a  (req_raw_temp_a),
      .req_raw_temp_b  (req_raw_temp_b),
      .req_raw_temp_c  (req_raw_temp_c),
      .req_table_index (req_table_index),
      .req_table_word  (req_table_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_press_a_avg (rsp_press_a_avg),
      .rsp_press_b_avg (rsp_press_b_avg),
      .rsp_temp_a_avg  (rsp_temp_a_avg),
      .rsp_temp_b_avg  (rsp_temp_b_avg),
      .rsp_temp_c_avg  (rsp_temp_c_avg),
      .rsp_tare_done   (rsp_tare_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ------------------------------------------------------------------
   // Testbench state
   // ------------------------------------------------------------------
   adc_item_type   adc_items_q[$];    // items waiting for the driver
   adc_item_type   drive_item;        // item currently on the request port
   adc_item_type   next_item;
   window_avg_type window_avgs_q[$];  // predicted averages, oldest first

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit csr_taken = 1'b0;
   int idle_cycles = 0;
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // generation-time view: table entries already written, current window
   bit lut_filled [LUT_DEPTH];
   int gen_min = CMIN_RESET;
   int gen_max = CMAX_RESET;

   int phase_min [NUM_PHASES] = '{0, 0, 4095, 3000, 1500, 1900};
   int phase_max [NUM_PHASES] = '{1024, 4096, 4096, 3000, 200, 3300};

   // predictor state, updated at each accepted transfer
   int                       cfg_min = CMIN_RESET;
   int                       cfg_max = CMAX_RESET;
   logic signed [PSUM_W-1:0] acc_press [2] = '{default: '0};
   logic signed [TSUM_W-1:0] acc_temp [3] = '{default: '0};
   int                       frames_in_window = 0;
   logic [CALIB_W-1:0]       tare_sum [2] = '{default: '0};
   logic [BASE_W-1:0]        tare_base [2] = '{BASE_RESET, BASE_RESET};
   logic [PROG_W-1:0]        tare_windows = '0;
   logic [TEMP_W-1:0]        lut_model [LUT_DEPTH];

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic longint code_to_mbar(input logic [CODE_W-1:0] code,
                                           input longint gain, input longint div);
      longint prod;
      prod = longint'(code) * gain * VREF_MV * MICRO;
      return prod / div / ADC_SPAN / R_LOW;
   endfunction

   // codes outside [min, max) or past the table depth contribute nothing
   function automatic logic signed [TSUM_W-1:0] temp_from_code(input logic [CODE_W-1:0] code);
      int c;
      int off;
      c = code;
      if (c < cfg_min || c >= cfg_max) return '0;
      off = c - cfg_min;
      if (off >= LUT_DEPTH) return '0;
      return {{(TSUM_W-TEMP_W){lut_model[off][TEMP_W-1]}}, lut_model[off]};
   endfunction

   task automatic accumulate_item(input adc_item_type it);
      longint                   pa;
      longint                   pb;
      logic signed [PSUM_W-1:0] avg_a;
      logic signed [PSUM_W-1:0] avg_b;
      logic signed [TSUM_W-1:0] avg_t [3];
      logic [CODE_W-1:0]        codes [3];
      window_avg_type           res;

      // table write: only the table changes, no result
      if (it.action == ACT_TABLE) begin
         lut_model[it.index] = it.word;
         return;
      end

      // convert to mbar and remove the tare offset; a base below 1000 adds
      pa = code_to_mbar(it.press_a, PA_GAIN, PA_DIV) - (longint'(tare_base[0]) - TARE_ZERO);
      pb = code_to_mbar(it.press_b, PB_GAIN, PB_DIV) - (longint'(tare_base[1]) - TARE_ZERO);
      acc_press[0] = acc_press[0] + PSUM_W'(pa);
      acc_press[1] = acc_press[1] + PSUM_W'(pb);

      codes[0] = it.temp_a;
      codes[1] = it.temp_b;
      codes[2] = it.temp_c;
      for (int k = 0; k < 3; k++) acc_temp[k] = acc_temp[k] + temp_from_code(codes[k]);

      frames_in_window++;
      if (frames_in_window < WINDOW) return;
      frames_in_window = 0;

      // close the window: arithmetic shift floors toward minus infinity
      avg_a = acc_press[0] >>> AVG_SH;
      avg_b = acc_press[1] >>> AVG_SH;
      for (int k = 0; k < 3; k++) begin
         avg_t[k] = acc_temp[k] >>> AVG_SH;
         acc_temp[k] = '0;
      end
      acc_press[0] = '0;
      acc_press[1] = '0;

      // sum the first eight averages, take the bases at the ninth
      if (tare_windows < CALIB_WINDOWS) begin
         tare_sum[0] = tare_sum[0] + {{(CALIB_W-PSUM_W){avg_a[PSUM_W-1]}}, avg_a};
         tare_sum[1] = tare_sum[1] + {{(CALIB_W-PSUM_W){avg_b[PSUM_W-1]}}, avg_b};
         tare_windows++;
      end else if (tare_windows == CALIB_WINDOWS) begin
         tare_base[0] = tare_sum[0][CALIB_SHIFT +: BASE_W];
         tare_base[1] = tare_sum[1][CALIB_SHIFT +: BASE_W];
         tare_windows = CALIB_DONE;
      end

      res.press_a   = avg_a[PRESS_W-1:0];
      res.press_b   = avg_b[PRESS_W-1:0];
      res.temp_a    = avg_t[0][TEMP_W-1:0];
      res.temp_b    = avg_t[1][TEMP_W-1:0];
      res.temp_c    = avg_t[2][TEMP_W-1:0];
      res.tare_done = (tare_windows == CALIB_DONE);
      window_avgs_q.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_frame(input logic [CODE_W-1:0] pa, input logic [CODE_W-1:0] pb,
                             input logic [CODE_W-1:0] ta, input logic [CODE_W-1:0] tb,
                             input logic [CODE_W-1:0] tc);
      adc_item_type it;
      it.action  = ACT_FRAME;
      it.press_a = pa;
      it.press_b = pb;
      it.temp_a  = ta;
      it.temp_b  = tb;
      it.temp_c  = tc;
      // table fields are ignored on a frame, so toggle them freely
      it.index   = TIDX_W'($urandom());
      it.word    = TEMP_W'($urandom());
      adc_items_q.push_back(it);
   endtask

   task automatic push_table(input logic [TIDX_W-1:0] idx, input logic [TEMP_W-1:0] word);
      adc_item_type it;
      it.action  = ACT_TABLE;
      it.press_a = CODE_W'($urandom());
      it.press_b = CODE_W'($urandom());
      it.temp_a  = CODE_W'($urandom());
      it.temp_b  = CODE_W'($urandom());
      it.temp_c  = CODE_W'($urandom());
      it.index   = idx;
      it.word    = word;
      adc_items_q.push_back(it);
      lut_filled[idx] = 1'b1;
   endtask

   // Pick a temperature code that never reads an unwritten table entry:
   // mostly a written in-window entry, otherwise any code that maps to zero.
   function automatic logic [CODE_W-1:0] pick_temp_code();
      int top;
      int off;
      int c;
      top = gen_max;
      if (gen_min + LUT_DEPTH < top) top = gen_min + LUT_DEPTH;
      if (top > 4096) top = 4096;
      if (top > gen_min && $urandom_range(99) < 70) begin
         for (int k = 0; k < 8; k++) begin
            off = $urandom_range(top - gen_min - 1);
            if (lut_filled[off]) return CODE_W'(gen_min + off);
         end
      end
      c = $urandom_range(4095);
      while (c >= gen_min && c < top && !lut_filled[c - gen_min]) c = $urandom_range(4095);
      return CODE_W'(c);
   endfunction

   // Use a window edge code as is when it is a legal code that reads a
   // written entry or maps to zero; otherwise fall back to a random pick.
   function automatic logic [CODE_W-1:0] edge_code(input int c);
      int top;
      top = gen_max;
      if (gen_min + LUT_DEPTH < top) top = gen_min + LUT_DEPTH;
      if (c < 0 || c > 4095) return pick_temp_code();
      if (c >= gen_min && c < top && !lut_filled[c - gen_min]) return pick_temp_code();
      return CODE_W'(c);
   endfunction

   task automatic write_csr(input csr_index_type which, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every item is in and every average is out, then let the
   // pipeline settle so a trailing table write or partial frame completes.
   task automatic drain_pipeline();
      do @(posedge clock);
      while (adc_items_q.size() != 0 || req_valid || window_avgs_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Request driver: advance on a transfer or an empty port, hold the
   // payload while stalled, idle at random.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (adc_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = adc_items_q.pop_front();
            req_valid       <= 1'b1;
            req_action      <= next_item.action;
            req_raw_press_a <= next_item.press_a;
            req_raw_press_b <= next_item.press_b;
            req_raw_temp_a  <= next_item.temp_a;
            req_raw_temp_b  <= next_item.temp_b;
            req_raw_temp_c  <= next_item.temp_c;
            req_table_index <= next_item.index;
            req_table_word  <= next_item.word;
            drive_item      <= next_item;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: stall at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: check results, track config, predict, watch for a hang.
   // Results are checked before the new request is predicted; a frame
   // cannot produce its own result at its accepting edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      window_avg_type want;
      if (!reset) begin
         req_taken = req_valid && (req_stall === 1'b0);
         rsp_taken = (rsp_valid === 1'b1) && !rsp_stall;
         csr_taken = csr_valid && (csr_ready === 1'b1);

         if (rsp_taken) begin
            if (window_avgs_q.size() == 0) begin
               $error("result transfer with no average pending");
               mismatches++;
            end else begin
               want = window_avgs_q.pop_front();
               check_field("press_a_avg", want.press_a, $unsigned(rsp_press_a_avg));
               check_field("press_b_avg", want.press_b, $unsigned(rsp_press_b_avg));
               check_field("temp_a_avg", want.temp_a, $unsigned(rsp_temp_a_avg));
               check_field("temp_b_avg", want.temp_b, $unsigned(rsp_temp_b_avg));
               check_field("temp_c_avg", want.temp_c, $unsigned(rsp_temp_c_avg));
               check_field("tare_done", want.tare_done, rsp_tare_done);
            end
         end

         if (csr_taken) begin
            if (csr_index == CSR_TEMP_CODE_MIN) cfg_min = csr_data[CMIN_W-1:0];
            else cfg_max = csr_data[CMAX_W-1:0];
         end

         if (req_taken) accumulate_item(drive_item);

         // any transfer on any channel counts as progress
         if (req_taken || rsp_taken || csr_taken) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, then phases that each set the temperature window
   // and an idle pattern, load edge entries, drive edge frames and then
   // a random mix of frames and table writes.
   // ------------------------------------------------------------------
   initial begin
      int pa;
      int pb;
      int off;

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         // sender idles lightly first, then heavily, then neither idles
         if (p < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 86;
         end else if (p < 4) begin
            send_idle_pct = 86;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // change the window only with nothing in flight
         write_csr(CSR_TEMP_CODE_MIN, phase_min[p]);
         write_csr(CSR_TEMP_CODE_MAX, phase_max[p]);
         gen_min = phase_min[p];
         gen_max = phase_max[p];

         // load the entries that the window edges reach
         push_table(TIDX_W'(0), TEMP_W'($urandom()));
         push_table(TIDX_W'(LUT_DEPTH - 1), TEMP_W'($urandom()));
         off = gen_max - 1 - gen_min;
         if (off >= 0 && off < LUT_DEPTH) push_table(TIDX_W'(off), TEMP_W'($urandom()));

         // frames at the window edges and the pressure extremes
         push_frame(CODE_W'(0), CODE_W'(4095), edge_code(gen_min - 1),
                    edge_code(gen_min), edge_code(gen_max - 1));
         push_frame(CODE_W'(4095), CODE_W'(0), edge_code(gen_max),
                    edge_code(gen_min + LUT_DEPTH - 1), edge_code(gen_min + LUT_DEPTH));

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < TABLE_PCT) begin
               push_table(TIDX_W'($urandom()), TEMP_W'($urandom()));
            end else begin
               pa = ($urandom_range(99) < 5) ? 4095 : $urandom_range(4095);
               pb = ($urandom_range(99) < 5) ? 0 : $urandom_range(4095);
               push_frame(CODE_W'(pa), CODE_W'(pb), pick_temp_code(),
                          pick_temp_code(), pick_temp_code());
            end
         end

         drain_pipeline();
      end

      if (mismatches == 0 && window_avgs_q.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
